/* design/solg_pkg.sv */
// ----------------------------------------------------------------------------
// solg_pkg
// Shared types, constants and tap tables for the selectable-order generator.
// ----------------------------------------------------------------------------
package solg_pkg;

  localparam int unsigned SEQ_W    = 31;
  localparam int unsigned SEQ_IW   = $clog2(SEQ_W);
  localparam int unsigned ORDER_W  = 6;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd16;

  // Register index carried on paddr[2]
  localparam logic REG_ORDER = 1'b0;

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [ORDER_W-1:0] order_t;

  typedef struct packed {
    seq_t state_nxt;
    logic state_we;
    seq_t value;
    logic unsupported;
  } step_res_t;

  function automatic seq_t tb(input int unsigned n);
    seq_t m;
    m = '0;
    m[SEQ_IW'(n - 1)] = 1'b1;
    return m;
  endfunction

  // Feedback taps per order; zero marks an order without an entry.
  function automatic seq_t tap_mask(input order_t order);
    seq_t t;
    unique case (order)
      6'd3:    t = tb(2) | tb(3);
      6'd4:    t = tb(3) | tb(4);
      6'd5:    t = tb(4) | tb(5);
      6'd6:    t = tb(5) | tb(6);
      6'd7:    t = tb(6) | tb(7);
      6'd8:    t = tb(2) | tb(3) | tb(4) | tb(8);
      6'd9:    t = tb(5) | tb(9);
      6'd10:   t = tb(7) | tb(10);
      6'd11:   t = tb(9) | tb(11);
      6'd12:   t = tb(2) | tb(10) | tb(11) | tb(12);
      6'd13:   t = tb(1) | tb(11) | tb(12) | tb(13);
      6'd14:   t = tb(2) | tb(12) | tb(13) | tb(14);
      6'd15:   t = tb(14) | tb(15);
      6'd16:   t = tb(11) | tb(13) | tb(14) | tb(16);
      6'd17:   t = tb(14) | tb(17);
      6'd18:   t = tb(11) | tb(18);
      6'd19:   t = tb(14) | tb(17) | tb(18) | tb(19);
      6'd20:   t = tb(17) | tb(20);
      6'd31:   t = tb(7) | tb(31);
      default: t = '0;
    endcase
    return t;
  endfunction

  // Low order bits set; valid for orders below 32.
  function automatic seq_t low_ones_mask(input order_t order);
    return ~({SEQ_W{1'b1}} << order[4:0]);
  endfunction

endpackage

/* design/solg_step.sv */
// ----------------------------------------------------------------------------
// solg_step
// One generator step: restart or advance, output mapping and order check.
// ----------------------------------------------------------------------------
module solg_step (
  input  solg_pkg::seq_t      state,
  input  solg_pkg::order_t    order,
  input  logic                restart,
  output solg_pkg::step_res_t res
);
  import solg_pkg::*;

  seq_t taps;
  seq_t mask;
  seq_t adv;
  logic fb;

  assign taps = tap_mask(order);
  assign mask = low_ones_mask(order);
  assign fb   = ^(state & taps);
  assign adv  = {state[SEQ_W-2:0], fb} & mask;

  always_comb begin
    res = '0;
    if (taps == '0) begin
      // hold state, flag the order
      res.state_nxt   = state;
      res.state_we    = 1'b0;
      res.value       = '0;
      res.unsupported = 1'b1;
    end else if (restart) begin
      res.state_nxt   = mask;
      res.state_we    = 1'b1;
      res.value       = mask;
      res.unsupported = 1'b0;
    end else begin
      res.state_nxt   = adv;
      res.state_we    = 1'b1;
      // show all ones as zero so zero appears in place of all ones
      res.value       = (adv == mask) ? '0 : adv;
      res.unsupported = 1'b0;
    end
  end

endmodule

/* design/selectable_order_lfsr_generator.sv */
// ----------------------------------------------------------------------------
// selectable_order_lfsr_generator
// Shift-register sequence generator with selectable order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_restart): each request reloads all ones
//   (in_restart=1) or advances one step (in_restart=0); unsupported orders hold.
//   Result channel (out_valid/out_stall): one result per request carrying
//   out_sequence_value and out_order_unsupported.
//   Config port (APB style): register "order" at address 0, 6 bits.
// Timing:
//   Each accepted result is registered in the output register, or in the
//   one-entry skid register when the receiver stalls; in_stall is high
//   only while that skid entry is occupied. One request per cycle is
//   taken while in_stall is low; the step is a single shift plus a tap XOR.
// Reset:
//   rst_n (synchronous) clears the shift register to zero, sets order to
//   16 and empties the output and skid registers.
// ----------------------------------------------------------------------------
module selectable_order_lfsr_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [solg_pkg::SEQ_W-1:0] out_sequence_value,
  output logic                       out_order_unsupported,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [solg_pkg::CFG_AW-1:0] paddr,
  input  logic [solg_pkg::CFG_DW-1:0] pwdata,
  output logic [solg_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import solg_pkg::*;

  order_t    order_r;
  seq_t      state_r;
  logic      out_valid_r;
  seq_t      out_value_r;
  logic      out_uns_r;
  logic      skid_valid_r;
  seq_t      skid_value_r;
  logic      skid_uns_r;

  step_res_t step;
  logic      accept;
  logic      out_free;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ORDER);
  assign prdata = (paddr[2] == REG_ORDER) ? {{(CFG_DW-ORDER_W){1'b0}}, order_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_wr) begin
      order_r <= pwdata[ORDER_W-1:0];
    end
  end

  solg_step u_step (
    .state   (state_r),
    .order   (order_r),
    .restart (in_restart),
    .res     (step)
  );

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept && step.state_we) begin
      state_r <= step.state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // drain skid first; accept is blocked while it holds a result
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_value_r <= skid_value_r;
        out_uns_r   <= skid_uns_r;
      end else if (accept) begin
        out_value_r <= step.value;
        out_uns_r   <= step.unsupported;
      end
    end else if (accept) begin
      skid_value_r <= step.value;
      skid_uns_r   <= step.unsupported;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sequence_value    = out_value_r;
  assign out_order_unsupported = out_uns_r;

endmodule
